// ===== hw/rtl/ttw_pkg.sv =====
// Shared types, sizes and helpers for the text terminal writer.
`timescale 1ns / 1ps

package ttw_pkg;

    // Screen geometry
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    // Field widths fixed by the item format
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [BYTE_W-1:0] COLOR_RESET  = 8'd2;
    localparam logic [BYTE_W-1:0] CHAR_BLANK   = 8'd0;

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM    = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLS);

    typedef enum logic [1:0] {
        OP_PUT       = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_READ      = 2'd2,
        OP_CLEAR     = 2'd3
    } ttw_op_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCROLL,
        S_BLANK,
        S_BS_RD,
        S_BS_CHK,
        S_RD_WAIT,
        S_CLEAR,
        S_DONE
    } ttw_state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BYTE_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } ttw_req_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [BYTE_W-1:0] cell_char;
        logic [BYTE_W-1:0] cell_color;
    } ttw_rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ttw_mem_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ttw_stat_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ROW_STEP + ADDR_W'(col);
    endfunction

endpackage

// ===== hw/rtl/ttw_ram.sv =====
// Simple dual-port cell memory with registered read data.
`timescale 1ns / 1ps

module ttw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ttw_ctrl.sv =====
// Sequencer: cursor, scroll copy, backspace scan and clear sweeps over the cell memory.
`timescale 1ns / 1ps

module ttw_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  ttw_pkg::ttw_req_t                req,
    input  logic [ttw_pkg::BYTE_W-1:0]       text_color,
    input  logic                             rsp_free,
    input  logic [ttw_pkg::CELL_W-1:0]       rdata,
    output ttw_pkg::ttw_mem_t                mem,
    output ttw_pkg::ttw_stat_t               stat,
    output ttw_pkg::ttw_rsp_t                rsp
);

    ttw_pkg::ttw_state_t state_reg, state_next;

    logic [ttw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [ttw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [ttw_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic                       pend_reg, pend_next;
    logic [ttw_pkg::ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [ttw_pkg::CELL_W-1:0] cell_reg, cell_next;

    logic [ttw_pkg::ADDR_W-1:0] cur_addr;
    logic [ttw_pkg::CELL_W-1:0] blank;
    logic                       rd_in_range;
    logic                       scan_more;
    ttw_pkg::ttw_op_t           op;

    assign cur_addr    = ttw_pkg::cell_addr(row_reg, col_reg);
    assign blank       = {text_color, ttw_pkg::CHAR_BLANK};
    assign rd_in_range = (int'(req.read_row) < ttw_pkg::ROWS)
                      && (int'(req.read_col) < ttw_pkg::COLS);
    assign scan_more   = (idx_reg != '0) && (rdata[ttw_pkg::BYTE_W-1:0] == ttw_pkg::CHAR_BLANK);
    assign op          = ttw_pkg::ttw_op_t'(req.operation);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttw_pkg::S_INIT;
            row_reg   <= '0;
            col_reg   <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        cell_reg      <= cell_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttw_pkg::S_INIT:
            begin
                if (idx_reg == ttw_pkg::CELL_LAST)
                    state_next = ttw_pkg::S_IDLE;
            end
            ttw_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        ttw_pkg::OP_PUT:
                        begin
                            if (req.char_code == ttw_pkg::NEWLINE_CODE)
                                state_next = (row_reg == ttw_pkg::LAST_ROW) ?
                                             ttw_pkg::S_SCROLL : ttw_pkg::S_DONE;
                            else if (col_reg == ttw_pkg::LAST_COL
                                     && row_reg == ttw_pkg::LAST_ROW)
                                state_next = ttw_pkg::S_SCROLL;
                            else
                                state_next = ttw_pkg::S_DONE;
                        end
                        ttw_pkg::OP_BACKSPACE:
                        begin
                            if (col_reg == '0 && row_reg != '0)
                                state_next = ttw_pkg::S_BS_RD;
                            else
                                state_next = ttw_pkg::S_DONE;
                        end
                        ttw_pkg::OP_READ:
                        begin
                            state_next = rd_in_range ? ttw_pkg::S_RD_WAIT : ttw_pkg::S_DONE;
                        end
                        ttw_pkg::OP_CLEAR:
                        begin
                            state_next = ttw_pkg::S_CLEAR;
                        end
                        default:
                        begin
                            state_next = ttw_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ttw_pkg::S_SCROLL:
            begin
                if (idx_reg == ttw_pkg::COPY_LAST)
                    state_next = ttw_pkg::S_BLANK;
            end
            ttw_pkg::S_BLANK:
            begin
                if (!pend_reg && idx_reg == ttw_pkg::CELL_LAST)
                    state_next = ttw_pkg::S_DONE;
            end
            ttw_pkg::S_BS_RD:
            begin
                state_next = ttw_pkg::S_BS_CHK;
            end
            ttw_pkg::S_BS_CHK:
            begin
                state_next = scan_more ? ttw_pkg::S_BS_RD : ttw_pkg::S_DONE;
            end
            ttw_pkg::S_RD_WAIT:
            begin
                state_next = ttw_pkg::S_DONE;
            end
            ttw_pkg::S_CLEAR:
            begin
                if (idx_reg == ttw_pkg::CELL_LAST)
                    state_next = ttw_pkg::S_DONE;
            end
            ttw_pkg::S_DONE:
            begin
                if (rsp_free)
                    state_next = ttw_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ttw_pkg::S_INIT;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        cell_next      = cell_reg;
        mem.we         = 1'b0;
        mem.waddr      = idx_reg;
        mem.wdata      = blank;
        mem.raddr      = idx_reg;

        // Drain the copy queued by the previous scroll read
        if (pend_reg)
        begin
            mem.we    = 1'b1;
            mem.waddr = pend_addr_reg;
            mem.wdata = rdata;
        end

        unique case (state_reg)
            ttw_pkg::S_INIT:
            begin
                mem.we    = 1'b1;
                mem.waddr = idx_reg;
                mem.wdata = {ttw_pkg::COLOR_RESET, ttw_pkg::CHAR_BLANK};
                idx_next  = (idx_reg == ttw_pkg::CELL_LAST) ? '0 : idx_reg + 1'b1;
            end
            ttw_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cell_next = '0;
                    idx_next  = '0;
                    unique case (op)
                        ttw_pkg::OP_PUT:
                        begin
                            if (req.char_code != ttw_pkg::NEWLINE_CODE)
                            begin
                                mem.we    = 1'b1;
                                mem.waddr = cur_addr;
                                mem.wdata = {text_color, req.char_code};
                            end
                            if (req.char_code == ttw_pkg::NEWLINE_CODE
                                || col_reg == ttw_pkg::LAST_COL)
                            begin
                                col_next = '0;
                                if (row_reg != ttw_pkg::LAST_ROW)
                                    row_next = row_reg + 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        ttw_pkg::OP_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next  = col_reg - 1'b1;
                                mem.we    = 1'b1;
                                mem.waddr = cur_addr - 1'b1;
                            end
                            else if (row_reg == '0)
                            begin
                                mem.we    = 1'b1;
                                mem.waddr = '0;
                            end
                            else
                            begin
                                // Start the backward scan at the end of the previous row
                                idx_next = cur_addr - 1'b1;
                                row_next = row_reg - 1'b1;
                                col_next = ttw_pkg::LAST_COL;
                            end
                        end
                        ttw_pkg::OP_READ:
                        begin
                            if (rd_in_range)
                                mem.raddr = ttw_pkg::cell_addr(req.read_row, req.read_col);
                        end
                        ttw_pkg::OP_CLEAR:
                        begin
                            row_next = '0;
                            col_next = '0;
                        end
                        default:
                        begin
                            cell_next = '0;
                        end
                    endcase
                end
            end
            ttw_pkg::S_SCROLL:
            begin
                // Read one row ahead, write back on the next cycle
                mem.raddr      = idx_reg + ttw_pkg::ROW_STEP;
                pend_next      = 1'b1;
                pend_addr_next = idx_reg;
                idx_next       = (idx_reg == ttw_pkg::COPY_LAST) ?
                                 ttw_pkg::BOTTOM : idx_reg + 1'b1;
            end
            ttw_pkg::S_BLANK:
            begin
                if (!pend_reg)
                begin
                    mem.we    = 1'b1;
                    mem.waddr = idx_reg;
                    mem.wdata = blank;
                    idx_next  = (idx_reg == ttw_pkg::CELL_LAST) ? '0 : idx_reg + 1'b1;
                end
            end
            ttw_pkg::S_BS_RD:
            begin
                mem.raddr = idx_reg;
            end
            ttw_pkg::S_BS_CHK:
            begin
                if (scan_more)
                begin
                    idx_next = idx_reg - 1'b1;
                    if (col_reg == '0)
                    begin
                        col_next = ttw_pkg::LAST_COL;
                        row_next = row_reg - 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
                else
                begin
                    mem.we    = 1'b1;
                    mem.waddr = idx_reg;
                    mem.wdata = blank;
                    idx_next  = '0;
                end
            end
            ttw_pkg::S_RD_WAIT:
            begin
                cell_next = rdata;
            end
            ttw_pkg::S_CLEAR:
            begin
                mem.we    = 1'b1;
                mem.waddr = idx_reg;
                mem.wdata = blank;
                idx_next  = (idx_reg == ttw_pkg::CELL_LAST) ? '0 : idx_reg + 1'b1;
            end
            ttw_pkg::S_DONE:
            begin
                cell_next = cell_reg;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Status and result
    always_comb
    begin
        stat.idle       = (state_reg == ttw_pkg::S_IDLE);
        stat.done       = (state_reg == ttw_pkg::S_DONE);
        rsp.cursor_row  = row_reg;
        rsp.cursor_col  = col_reg;
        rsp.cell_char   = cell_reg[ttw_pkg::BYTE_W-1:0];
        rsp.cell_color  = cell_reg[ttw_pkg::CELL_W-1:ttw_pkg::BYTE_W];
    end

endmodule

// ===== hw/rtl/text_terminal_writer_top.sv =====
// Top level of the text terminal writer: config register, sequencer, cell memory, result register.
`timescale 1ns / 1ps

// Put char without a scroll, mid-row backspace and out-of-range read go from idle straight to
// the done state; an in-range read passes through a read-wait state first. A scroll copies one
// cell per cycle through the memory's one write port, clear writes every cell, and a backspace
// at column 0 below the top row scans back cell by cell (read, then check). The block takes one
// item at a time and accepts the next only once idle again; a stalled result holds the sequencer when done.
// Reset: cursor homes, the color register loads 2, and a clearing pass writes every cell
// before the first item is accepted.
module text_terminal_writer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  ttw_pkg::ttw_req_t           req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output ttw_pkg::ttw_rsp_t           rsp,
    input  logic                        cfg_wr_en,
    input  logic [ttw_pkg::BYTE_W-1:0]  cfg_wr_data
);

    logic [ttw_pkg::BYTE_W-1:0] text_color_reg, text_color_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    ttw_pkg::ttw_rsp_t          rsp_reg, rsp_next;

    ttw_pkg::ttw_mem_t          mem;
    ttw_pkg::ttw_stat_t         stat;
    ttw_pkg::ttw_rsp_t          ctrl_rsp;
    logic [ttw_pkg::CELL_W-1:0] rdata;
    logic                       start;
    logic                       rsp_free;
    logic                       load;

    // Accept a new item whenever the sequencer is idle, even while a result waits
    assign req_ready = stat.idle;
    assign start     = req_valid && req_ready;
    // The result register frees up in the same cycle its item is taken
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign load      = stat.done && rsp_free;

    ttw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .text_color (text_color_reg),
        .rsp_free   (rsp_free),
        .rdata      (rdata),
        .mem        (mem),
        .stat       (stat),
        .rsp        (ctrl_rsp)
    );

    ttw_ram #(
        .DEPTH (ttw_pkg::CELLS),
        .WIDTH (ttw_pkg::CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    // Hold the color until the next config write
    always_comb
    begin
        text_color_next = cfg_wr_en ? cfg_wr_data : text_color_reg;
    end

    // Result register: load on completion, drop valid when the item is taken
    always_comb
    begin
        rsp_next       = load ? ctrl_rsp : rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= ttw_pkg::COLOR_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            text_color_reg <= text_color_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // The cursor never leaves the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (int'(rsp_reg.cursor_row) < ttw_pkg::ROWS)
                       && (int'(rsp_reg.cursor_col) < ttw_pkg::COLS))
        else $error("cursor out of range in result");

    // One item at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !req_ready)
        else $error("item accepted while previous one still in flight");

    // A result appears only when the sequencer has finished an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(stat.done))
        else $error("result valid without a finished item");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the text terminal writer, run against a cycle-free screen model.

module tb_top;
    import ttw_pkg::*;

    // Cover the worst stimulus mix (scrolls, clears, long backspace scans, longest gaps
    // and stalls) several times over.
    localparam int CYCLE_LIMIT  = 40_000_000;
    localparam int TAIL_CYCLES  = 200;
    localparam int PHASE_COUNT  = 10;
    localparam int REPORT_LIMIT = 100;

    // Random phase flavors: each one weights the operations differently.
    typedef enum int {
        MIX_PHASE,
        SCROLL_PHASE,
        FILL_PHASE,
        ERASE_PHASE
    } phase_kind_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              req_valid   = 1'b0;
    logic              req_ready;
    ttw_req_t          req         = '0;
    logic              rsp_valid;
    logic              rsp_ready   = 1'b0;
    ttw_rsp_t          rsp;
    logic              cfg_wr_en   = 1'b0;
    logic [BYTE_W-1:0] cfg_wr_data = '0;

    // Screen model: one cell per entry, attribute in the upper byte, character in the lower.
    logic [CELL_W-1:0] screen_cells [CELLS];
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [BYTE_W-1:0] text_attr;

    ttw_req_t pending_req_q [$];
    ttw_rsp_t expected_rsp_q [$];

    logic req_taken   = 1'b0;
    logic no_idle     = 1'b0;
    int   send_gap    = 0;
    int   stall_left  = 0;
    int   cycle_count = 0;
    int   error_count = 0;

    text_terminal_writer_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------

    // Blank every cell with the current attribute and home the cursor.
    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen_cells[i] = {text_attr, CHAR_BLANK};
        cur_row = '0;
        cur_col = '0;
    endfunction

    // Step down one row; on the bottom row shift everything up and blank the last row.
    function automatic void next_line();
        if (cur_row == LAST_ROW)
        begin
            for (int i = COLS; i < CELLS; i++)
                screen_cells[i - COLS] = screen_cells[i];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen_cells[i] = {text_attr, CHAR_BLANK};
        end
        else
        begin
            cur_row = cur_row + 1'b1;
        end
    endfunction

    // Apply one operation to the model and return the result the block must produce.
    function automatic ttw_rsp_t screen_step(input ttw_req_t item);
        ttw_rsp_t result;
        int       idx;
        result = '0;
        case (item.operation)
            OP_PUT:
            begin
                if (item.char_code == NEWLINE_CODE)
                begin
                    cur_col = '0;
                    next_line();
                end
                else
                begin
                    screen_cells[int'(cur_row) * COLS + int'(cur_col)] =
                        {text_attr, item.char_code};
                    if (cur_col == LAST_COL)
                    begin
                        cur_col = '0;
                        next_line();
                    end
                    else
                    begin
                        cur_col = cur_col + 1'b1;
                    end
                end
            end
            OP_BACKSPACE:
            begin
                if (cur_col != '0)
                begin
                    cur_col = cur_col - 1'b1;
                    idx = int'(cur_row) * COLS + int'(cur_col);
                end
                else if (cur_row == '0)
                begin
                    idx = 0;
                end
                else
                begin
                    // Walk back from the end of the previous row over blank characters.
                    idx = int'(cur_row) * COLS - 1;
                    while (idx > 0 && screen_cells[idx][BYTE_W-1:0] == CHAR_BLANK)
                        idx--;
                    cur_row = ROW_W'(idx / COLS);
                    cur_col = COL_W'(idx % COLS);
                end
                screen_cells[idx] = {text_attr, CHAR_BLANK};
            end
            OP_READ:
            begin
                // Out-of-range coordinates read back as all zero.
                if (int'(item.read_row) < ROWS && int'(item.read_col) < COLS)
                begin
                    idx = int'(item.read_row) * COLS + int'(item.read_col);
                    result.cell_char  = screen_cells[idx][BYTE_W-1:0];
                    result.cell_color = screen_cells[idx][CELL_W-1:BYTE_W];
                end
            end
            default:
            begin
                blank_screen();
            end
        endcase
        result.cursor_row = cur_row;
        result.cursor_col = cur_col;
        return result;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, a few long ones; none at all in burst phases.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 40)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic ttw_req_t make_item(input ttw_op_t op, input logic [BYTE_W-1:0] code,
                                           input int row, input int col);
        ttw_req_t item;
        item.operation = op;
        item.char_code = code;
        item.read_row  = ROW_W'(row);
        item.read_col  = COL_W'(col);
        return item;
    endfunction

    function automatic int phase_length(input phase_kind_t kind);
        case (kind)
            SCROLL_PHASE: return 150;
            FILL_PHASE:   return 220;
            ERASE_PHASE:  return 180;
            default:      return 200;
        endcase
    endfunction

    // Draw one item; the flavor sets the operation mix and how often a newline appears.
    function automatic ttw_req_t random_item(input phase_kind_t kind);
        ttw_req_t item;
        int       put_pct;
        int       bs_pct;
        int       rd_pct;
        int       nl_pct;
        int       pick;
        int       sub;
        item.operation = 2'($urandom);
        item.char_code = 8'($urandom);
        item.read_row  = 5'($urandom);
        item.read_col  = 7'($urandom);
        case (kind)
            SCROLL_PHASE: begin put_pct = 85; bs_pct = 5;  rd_pct = 10; nl_pct = 30; end
            FILL_PHASE:   begin put_pct = 80; bs_pct = 8;  rd_pct = 12; nl_pct = 1;  end
            ERASE_PHASE:  begin put_pct = 45; bs_pct = 40; rd_pct = 15; nl_pct = 15; end
            default:      begin put_pct = 65; bs_pct = 12; rd_pct = 18; nl_pct = 6;  end
        endcase
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        if (pick < put_pct)
        begin
            item.operation = OP_PUT;
            // Blank characters stored on purpose give backspace scans something to skip.
            if (sub < nl_pct)
                item.char_code = NEWLINE_CODE;
            else if (sub < nl_pct + 4)
                item.char_code = CHAR_BLANK;
        end
        else if (pick < put_pct + bs_pct)
        begin
            item.operation = OP_BACKSPACE;
        end
        else if (pick < put_pct + bs_pct + rd_pct)
        begin
            item.operation = OP_READ;
            // Keep the full-width draw for out-of-range reads; else aim at the screen.
            if (sub >= 15 && sub < 60)
            begin
                item.read_row = ROW_W'($urandom_range(0, 3));
                item.read_col = COL_W'($urandom_range(0, COLS - 1));
            end
            else if (sub >= 60)
            begin
                item.read_row = ROW_W'($urandom_range(0, ROWS - 1));
                item.read_col = COL_W'($urandom_range(0, COLS - 1));
            end
        end
        else
        begin
            item.operation = OP_CLEAR;
        end
        return item;
    endfunction

    // Hold until every queued item is accepted and every result has come back.
    task automatic wait_drained();
        while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Pulse the color write for one edge; only call this with the block drained.
    task automatic write_color(input logic [BYTE_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        text_attr    = value;
    endtask

    function automatic void check_field(input string name, input logic [BYTE_W-1:0] exp_val,
                                        input logic [BYTE_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            if (error_count < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: present items from the pending queue at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            // Drop or replace the item only after its handshake; pick the next gap then.
            if (req_taken)
            begin
                req_taken = 1'b0;
                send_gap  = idle_gap();
            end
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_req_q.size() != 0)
            begin
                req       <= pending_req_q.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, with runs of full readiness in between.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = idle_gap();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted item, check each accepted result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                expected_rsp_q.push_back(screen_step(req));
                req_taken = 1'b1;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: unexpected result, expected none, actual %h",
                                 $time, rsp);
                    error_count++;
                end
                else
                begin
                    ttw_rsp_t exp_rsp;
                    exp_rsp = expected_rsp_q.pop_front();
                    check_field("cursor_row", BYTE_W'(exp_rsp.cursor_row),
                                BYTE_W'(rsp.cursor_row));
                    check_field("cursor_col", BYTE_W'(exp_rsp.cursor_col),
                                BYTE_W'(rsp.cursor_col));
                    check_field("cell_char", exp_rsp.cell_char, rsp.cell_char);
                    check_field("cell_color", exp_rsp.cell_color, rsp.cell_color);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed items, then random phases under several colors
    // ------------------------------------------------------------------
    initial
    begin
        phase_kind_t kind_seq [PHASE_COUNT];
        phase_kind_t kind;
        int          count;
        kind_seq = '{MIX_PHASE, SCROLL_PHASE, FILL_PHASE, ERASE_PHASE, MIX_PHASE,
                     SCROLL_PHASE, MIX_PHASE, ERASE_PHASE, FILL_PHASE, MIX_PHASE};

        // Mirror the reset state: default color, blank screen, cursor home.
        text_attr = COLOR_RESET;
        blank_screen();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset color: reads at both corners and out of range,
        // backspace at the top-left, extreme character codes, a backspace that skips a
        // stored blank across the row boundary, a mid-row backspace, clear, and
        // backspace scans that run all the way back to the first cell.
        pending_req_q.push_back(make_item(OP_READ, 8'h00, 0, 0));
        pending_req_q.push_back(make_item(OP_READ, 8'hFF, ROWS - 1, COLS - 1));
        pending_req_q.push_back(make_item(OP_READ, 8'h00, ROWS, 0));
        pending_req_q.push_back(make_item(OP_READ, 8'h00, 0, COLS));
        pending_req_q.push_back(make_item(OP_READ, 8'hFF, 31, 127));
        pending_req_q.push_back(make_item(OP_BACKSPACE, 8'hFF, 31, 127));
        pending_req_q.push_back(make_item(OP_PUT, 8'h41, 0, 0));
        pending_req_q.push_back(make_item(OP_PUT, 8'hFF, 0, 0));
        pending_req_q.push_back(make_item(OP_PUT, CHAR_BLANK, 0, 0));
        pending_req_q.push_back(make_item(OP_PUT, NEWLINE_CODE, 0, 0));
        pending_req_q.push_back(make_item(OP_BACKSPACE, 8'h00, 0, 0));
        pending_req_q.push_back(make_item(OP_BACKSPACE, 8'h00, 0, 0));
        pending_req_q.push_back(make_item(OP_PUT, 8'h20, 0, 0));
        pending_req_q.push_back(make_item(OP_PUT, 8'h7E, 0, 0));
        pending_req_q.push_back(make_item(OP_READ, 8'h00, 0, 0));
        pending_req_q.push_back(make_item(OP_READ, 8'h00, 0, 1));
        pending_req_q.push_back(make_item(OP_CLEAR, 8'hFF, 31, 127));
        pending_req_q.push_back(make_item(OP_READ, 8'h00, 0, 1));
        pending_req_q.push_back(make_item(OP_PUT, NEWLINE_CODE, 0, 0));
        pending_req_q.push_back(make_item(OP_BACKSPACE, 8'h00, 0, 0));
        pending_req_q.push_back(make_item(OP_PUT, NEWLINE_CODE, 0, 0));
        pending_req_q.push_back(make_item(OP_PUT, NEWLINE_CODE, 0, 0));
        pending_req_q.push_back(make_item(OP_BACKSPACE, 8'h00, 0, 0));
        pending_req_q.push_back(make_item(OP_READ, 8'h00, 2, 0));
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            kind  = kind_seq[p];
            count = phase_length(kind);
            // Hit both color extremes and each nibble alone first, then random colors.
            case (p)
                0:       write_color(8'h00);
                1:       write_color(8'hFF);
                2:       write_color(8'h0F);
                3:       write_color(8'hF0);
                default: write_color(BYTE_W'($urandom));
            endcase
            // Run a couple of phases with no gaps between items on the request side.
            no_idle = (p == 3 || p == 6);
            for (int n = 0; n < count; n++)
            begin
                // In mixed phases, pause the sender halfway until all results are in.
                if (kind == MIX_PHASE && n == count / 2)
                    wait_drained();
                pending_req_q.push_back(random_item(kind));
            end
            wait_drained();
        end

        // Catch any stray result after the last expected one.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_rsp_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected %h, actual none",
                     $time, expected_rsp_q.size(), expected_rsp_q[0]);
            error_count++;
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
